/* rtl/framebuffer_scanout_color_convert_unit_macros.svh */
// Assertion helpers shared by the scanout RTL.
`ifndef FRAMEBUFFER_SCANOUT_COLOR_CONVERT_UNIT_MACROS_SVH
`define FRAMEBUFFER_SCANOUT_COLOR_CONVERT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FBSCAN_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (prop)) else $error(msg);
`define FBSCAN_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBSCAN_ASSERT(lbl, ck, rn, prop, msg)
`define FBSCAN_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

/* rtl/fbscan_pkg.sv */
package fbscan_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] OPAQUE_BLACK = 32'hff00_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_MODE = 3'd0,
        REG_FB_ORIGIN  = 3'd1,
        REG_FB_STRIDE  = 3'd2,
        REG_X_OFFSET   = 3'd3,
        REG_Y_OFFSET   = 3'd4,
        REG_WIDTH      = 3'd5,
        REG_HEIGHT     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_BLANK  = 2'd0,
        MODE_ERR    = 2'd1,
        MODE_RGBA16 = 2'd2,
        MODE_RGBA32 = 2'd3
    } pixel_mode_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    // Clamp a programmed size to the raster limit.
    function automatic logic [10:0] eff_size(logic [10:0] v, logic [12:0] lim);
        logic [10:0] r;
        r = v;
        if (13'(v) > lim)
        begin
            r = lim[10:0];
        end
        return r;
    endfunction

    // 5-bit channel widened as (c << 3) | c.
    function automatic logic [7:0] expand5(logic [4:0] c);
        return {c, 3'b000} | {3'b000, c};
    endfunction

    // RGBA5551 to ABGR8888.
    function automatic logic [31:0] convert16(logic [15:0] c);
        logic [7:0] a;
        a = c[0] ? 8'hff : 8'h00;
        return {a, expand5(c[5:1]), expand5(c[10:6]), expand5(c[15:11])};
    endfunction

    function automatic logic [31:0] byte_swap(logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* rtl/fbscan_front.sv */
`include "framebuffer_scanout_color_convert_unit_macros.svh"

module fbscan_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ENTRY_W    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               op,
    input  logic [31:0]        mem_data,
    input  logic [10:0]        active_width,
    input  logic [10:0]        active_height,
    input  logic [11:0]        y_pixel_offset,
    input  logic [11:0]        fb_stride,
    output logic [ENTRY_W-1:0] entry
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int YSW = ((YW > 12) ? YW : 12) + 1;
    localparam int LBW = YSW + 12;

    typedef struct packed {
        logic           pix;
        logic [31:0]    data;
        logic [XW-1:0]  cur_x;
        logic [YW-1:0]  cur_y;
        logic           last;
        logic           active;
        logic [LBW-1:0] line_base;
        logic [XW-1:0]  next_x;
    } entry_t;

    logic [XW-1:0]  raster_x_reg, raster_x_next;
    logic [YW-1:0]  raster_y_reg, raster_y_next;
    logic [LBW-1:0] line_base_reg, line_base_next;
    logic           active_reg, active_next;

    logic [10:0]    w;
    logic [10:0]    h;
    logic [XW:0]    x_inc;
    logic [YW:0]    y_inc;
    logic           line_end;
    logic           frame_end;
    logic [YW-1:0]  y_mul;
    logic [YSW-1:0] y_sum;
    logic [LBW-1:0] lb_prod;
    logic           pix;
    logic           last;
    entry_t         ent;

    assign w = fbscan_pkg::eff_size(active_width, 13'(MAX_WIDTH));
    assign h = fbscan_pkg::eff_size(active_height, 13'(MAX_HEIGHT));

    assign x_inc = (XW+1)'(raster_x_reg) + (XW+1)'(1);
    assign y_inc = (YW+1)'(raster_y_reg) + (YW+1)'(1);

    // carry out means the counter wrapped: treat as end of line/frame
    assign line_end  = x_inc[XW] || (13'(x_inc[XW-1:0]) >= 13'(w));
    assign frame_end = y_inc[YW] || (13'(y_inc[YW-1:0]) >= 13'(h));

    // line base of the line being entered (first line on a start)
    assign y_mul   = (fbscan_pkg::op_t'(op) == fbscan_pkg::OP_START) ? '0 : y_inc[YW-1:0];
    assign y_sum   = YSW'(y_mul) + YSW'(y_pixel_offset);
    assign lb_prod = LBW'(y_sum) * LBW'(fb_stride);

    always_comb
    begin
        raster_x_next  = raster_x_reg;
        raster_y_next  = raster_y_reg;
        line_base_next = line_base_reg;
        active_next    = active_reg;
        pix            = 1'b0;
        last           = 1'b0;
        if (fbscan_pkg::op_t'(op) == fbscan_pkg::OP_START)
        begin
            raster_x_next  = '0;
            raster_y_next  = '0;
            line_base_next = lb_prod;
            active_next    = (w != '0) && (h != '0);
        end
        else if (active_reg)
        begin
            pix = 1'b1;
            if (line_end)
            begin
                raster_x_next  = '0;
                raster_y_next  = y_inc[YW-1:0];
                line_base_next = lb_prod;
                if (frame_end)
                begin
                    last           = 1'b1;
                    active_next    = 1'b0;
                    raster_y_next  = '0;
                    line_base_next = '0;
                end
            end
            else
            begin
                raster_x_next = x_inc[XW-1:0];
            end
        end
    end

    always_comb
    begin
        ent.pix       = pix;
        ent.data      = mem_data;
        ent.cur_x     = raster_x_reg;
        ent.cur_y     = raster_y_reg;
        ent.last      = last;
        ent.active    = active_next;
        ent.line_base = line_base_next;
        ent.next_x    = raster_x_next;
    end

    assign entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_x_reg  <= '0;
            raster_y_reg  <= '0;
            line_base_reg <= '0;
            active_reg    <= 1'b0;
        end
        else if (push)
        begin
            raster_x_reg  <= raster_x_next;
            raster_y_reg  <= raster_y_next;
            line_base_reg <= line_base_next;
            active_reg    <= active_next;
        end
    end

    `FBSCAN_ASSERT(a_idle_x_zero, clk, rst_n, !active_reg |-> (raster_x_reg == '0), "raster x not parked while idle")

endmodule

/* rtl/fbscan_queue.sv */
`include "framebuffer_scanout_color_convert_unit_macros.svh"

module fbscan_queue #(
    parameter int DEPTH = 4,
    parameter int W     = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         full,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `FBSCAN_ASSERT(a_q_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count over depth")
    `FBSCAN_ASSERT(a_q_empty_ptrs, clk, rst_n, empty |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers differ while empty")

endmodule

/* rtl/fbscan_back.sv */
`include "framebuffer_scanout_color_convert_unit_macros.svh"

module fbscan_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int ENTRY_W    = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  logic [ENTRY_W-1:0]        q_data,
    output logic                      q_pop,
    input  fbscan_pkg::pixel_mode_t   pixel_mode,
    input  logic [23:0]               fb_origin,
    input  logic [11:0]               x_pixel_offset,
    input  logic [10:0]               active_width,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [31:0]               fetch_addr,
    output logic                      fetch_valid,
    output logic [31:0]               pixel_color,
    output logic [19:0]               pixel_index,
    output logic                      pixel_valid,
    output logic                      frame_last,
    output logic                      mode_error
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int YSW = ((YW > 12) ? YW : 12) + 1;
    localparam int LBW = YSW + 12;
    localparam int IW  = YW + 12;

    typedef struct packed {
        logic           pix;
        logic [31:0]    data;
        logic [XW-1:0]  cur_x;
        logic [YW-1:0]  cur_y;
        logic           last;
        logic           active;
        logic [LBW-1:0] line_base;
        logic [XW-1:0]  next_x;
    } entry_t;

    // stage A: request taken from the queue
    logic   a_valid_reg, a_valid_next;
    entry_t a_reg;

    // stage B: index, pixel offset and color
    logic        b_valid_reg, b_valid_next;
    logic [19:0] b_index_reg, b_index_next;
    logic [31:0] b_offset_reg, b_offset_next;
    logic [31:0] b_color_reg, b_color_next;
    logic        b_pvalid_reg, b_pvalid_next;
    logic        b_last_reg;
    logic        b_active_reg;

    // output register
    logic        o_valid_reg, o_valid_next;
    logic [31:0] o_addr_reg, o_addr_next;
    logic        o_fvalid_reg;
    logic [31:0] o_color_reg;
    logic [19:0] o_index_reg;
    logic        o_pvalid_reg;
    logic        o_last_reg;
    logic        o_err_reg;

    logic        en_o;
    logic        en_b;
    logic        en_a;
    logic [10:0] w;
    logic [IW-1:0] idx_full;
    logic [31:0] byte_off;

    assign en_o  = !o_valid_reg || !out_stall;
    assign en_b  = !b_valid_reg || en_o;
    assign en_a  = !a_valid_reg || en_b;
    assign q_pop = en_a && !q_empty;

    assign a_valid_next = q_pop ? 1'b1 : (en_b ? 1'b0 : a_valid_reg);
    assign b_valid_next = en_b ? a_valid_reg : b_valid_reg;
    assign o_valid_next = en_o ? b_valid_reg : o_valid_reg;

    assign w = fbscan_pkg::eff_size(active_width, 13'(MAX_WIDTH));

    assign idx_full = IW'(a_reg.cur_y) * IW'(w) + IW'(a_reg.cur_x);

    always_comb
    begin
        b_index_next  = '0;
        b_color_next  = '0;
        b_pvalid_next = 1'b0;
        b_offset_next = 32'(a_reg.line_base) + 32'(a_reg.next_x) + 32'(x_pixel_offset);
        if (a_reg.pix)
        begin
            b_index_next = 20'(idx_full);
            case (pixel_mode)
                fbscan_pkg::MODE_BLANK:
                begin
                    b_color_next  = fbscan_pkg::OPAQUE_BLACK;
                    b_pvalid_next = 1'b1;
                end
                fbscan_pkg::MODE_RGBA16:
                begin
                    b_color_next  = fbscan_pkg::convert16(a_reg.data[15:0]);
                    b_pvalid_next = 1'b1;
                end
                fbscan_pkg::MODE_RGBA32:
                begin
                    b_color_next  = fbscan_pkg::byte_swap(a_reg.data);
                    b_pvalid_next = 1'b1;
                end
                default:
                begin
                    b_color_next  = '0;
                    b_pvalid_next = 1'b0;
                end
            endcase
        end
    end

    // 4 bytes per pixel in 32-bit mode, 2 otherwise
    assign byte_off = (pixel_mode == fbscan_pkg::MODE_RGBA32) ?
                      {b_offset_reg[29:0], 2'b00} : {b_offset_reg[30:0], 1'b0};
    assign o_addr_next = b_active_reg ? (32'(fb_origin) + byte_off) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_reg <= entry_t'(q_data);
        end
        if (en_b)
        begin
            b_index_reg  <= b_index_next;
            b_offset_reg <= b_offset_next;
            b_color_reg  <= b_color_next;
            b_pvalid_reg <= b_pvalid_next;
            b_last_reg   <= a_reg.last;
            b_active_reg <= a_reg.active;
        end
        if (en_o)
        begin
            o_addr_reg   <= o_addr_next;
            o_fvalid_reg <= b_active_reg;
            o_color_reg  <= b_color_reg;
            o_index_reg  <= b_index_reg;
            o_pvalid_reg <= b_pvalid_reg;
            o_last_reg   <= b_last_reg;
            o_err_reg    <= (pixel_mode == fbscan_pkg::MODE_ERR);
        end
    end

    assign out_valid   = o_valid_reg;
    assign fetch_addr  = o_addr_reg;
    assign fetch_valid = o_fvalid_reg;
    assign pixel_color = o_color_reg;
    assign pixel_index = o_index_reg;
    assign pixel_valid = o_pvalid_reg;
    assign frame_last  = o_last_reg;
    assign mode_error  = o_err_reg;

    `FBSCAN_ASSERT_NEXT(a_stage_a_hold, clk, rst_n, a_valid_reg && !en_b, a_valid_reg, "stage A request dropped while blocked")
    `FBSCAN_ASSERT_NEXT(a_stage_b_hold, clk, rst_n, b_valid_reg && !en_o, b_valid_reg && $stable(b_index_reg), "stage B request changed while blocked")

endmodule

/* rtl/framebuffer_scanout_color_convert_unit.sv */
// Channel   Handshake              Payload
// input     in_valid / in_stall    op, mem_data
// output    out_valid / out_stall  fetch_addr, fetch_valid, pixel_color,
//                                  pixel_index, pixel_valid, frame_last, mode_error
// config    cfg_we                 cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; a result passes through the
// queue, stage A, stage B and the output register after its request is taken.
// Raster state advances in the front end at accept; a 4-entry queue feeds the back end.
// in_stall rises only when that queue is full; out_stall freezes the output
// register and backs up through stages B and A into the queue.
// Reset idles the raster and loads the register defaults (320 x 240, blank mode).

module framebuffer_scanout_color_convert_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [31:0]                       mem_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [31:0]                       fetch_addr,
    output logic                              fetch_valid,
    output logic [31:0]                       pixel_color,
    output logic [19:0]                       pixel_index,
    output logic                              pixel_valid,
    output logic                              frame_last,
    output logic                              mode_error,
    input  logic                              cfg_we,
    input  logic [fbscan_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbscan_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int XW      = $clog2(MAX_WIDTH);
    localparam int YW      = $clog2(MAX_HEIGHT);
    localparam int YSW     = ((YW > 12) ? YW : 12) + 1;
    localparam int LBW     = YSW + 12;
    localparam int ENTRY_W = 1 + 32 + XW + YW + 1 + 1 + LBW + XW;

    fbscan_pkg::pixel_mode_t pixel_mode_reg;
    logic [23:0]             fb_origin_reg;
    logic [11:0]             fb_stride_reg;
    logic [11:0]             x_offset_reg;
    logic [11:0]             y_offset_reg;
    logic [10:0]             width_reg;
    logic [10:0]             height_reg;

    logic               push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] front_entry;
    logic [ENTRY_W-1:0] q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= fbscan_pkg::MODE_BLANK;
            fb_origin_reg  <= '0;
            fb_stride_reg  <= '0;
            x_offset_reg   <= '0;
            y_offset_reg   <= '0;
            width_reg      <= 11'd320;
            height_reg     <= 11'd240;
        end
        else if (cfg_we)
        begin
            case (fbscan_pkg::cfg_reg_t'(cfg_index))
                fbscan_pkg::REG_PIXEL_MODE: pixel_mode_reg <= fbscan_pkg::pixel_mode_t'(cfg_data[1:0]);
                fbscan_pkg::REG_FB_ORIGIN:  fb_origin_reg  <= cfg_data;
                fbscan_pkg::REG_FB_STRIDE:  fb_stride_reg  <= cfg_data[11:0];
                fbscan_pkg::REG_X_OFFSET:   x_offset_reg   <= cfg_data[11:0];
                fbscan_pkg::REG_Y_OFFSET:   y_offset_reg   <= cfg_data[11:0];
                fbscan_pkg::REG_WIDTH:      width_reg      <= cfg_data[10:0];
                fbscan_pkg::REG_HEIGHT:     height_reg     <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    fbscan_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .op             (op),
        .mem_data       (mem_data),
        .active_width   (width_reg),
        .active_height  (height_reg),
        .y_pixel_offset (y_offset_reg),
        .fb_stride      (fb_stride_reg),
        .entry          (front_entry)
    );

    fbscan_queue #(
        .DEPTH (fbscan_pkg::QUEUE_DEPTH),
        .W     (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_entry),
        .pop   (q_pop),
        .dout  (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    fbscan_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .pixel_mode     (pixel_mode_reg),
        .fb_origin      (fb_origin_reg),
        .x_pixel_offset (x_offset_reg),
        .active_width   (width_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fetch_addr     (fetch_addr),
        .fetch_valid    (fetch_valid),
        .pixel_color    (pixel_color),
        .pixel_index    (pixel_index),
        .pixel_valid    (pixel_valid),
        .frame_last     (frame_last),
        .mode_error     (mode_error)
    );

endmodule
